// ===== rtl/dtcd_pkg.sv =====
package dtcd_pkg;

    // Verdict codes carried on the result item
    typedef enum logic [1:0] {
        VERDICT_PASSED = 2'd0,
        VERDICT_FAILED = 2'd1,
        VERDICT_OPEN   = 2'd2
    } verdict_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILED_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSED_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LAMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RESTORE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCATION     = 3'd5;

    localparam int unsigned CFG_DATA_W = 8;

    // Status byte patterns written to nonvolatile memory
    localparam logic [3:0] BYTE_ON_FAIL = 4'h7;
    localparam logic [3:0] BYTE_ON_PASS = 4'h2;

    // Reset values of the configuration registers
    localparam logic [6:0]        FAILED_THR_RST = 7'd10;
    localparam logic signed [7:0] PASSED_THR_RST = -8'sd10;

    typedef struct packed {
        logic [6:0]        failed_threshold;
        logic signed [7:0] passed_threshold;
        logic              warning_lamp;
        logic              auto_restore;
        logic              critical_code;
        logic [7:0]        code_location;
    } cfg_t;

    // Result of one step, in port order
    typedef struct packed {
        verdict_t   verdict;
        logic       store_request;
        logic [7:0] store_location;
        logic [3:0] store_byte;
        logic [4:0] status_flags;
    } res_t;

endpackage

// ===== rtl/dtcd_cfg_regs.sv =====
module dtcd_cfg_regs
    import dtcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_FAILED_THR:   cfg_next.failed_threshold = wr_data[6:0];
                CFG_PASSED_THR:   cfg_next.passed_threshold = signed'(wr_data);
                CFG_WARNING_LAMP: cfg_next.warning_lamp     = wr_data[0];
                CFG_AUTO_RESTORE: cfg_next.auto_restore     = wr_data[0];
                CFG_CRITICAL:     cfg_next.critical_code    = wr_data[0];
                CFG_LOCATION:     cfg_next.code_location    = wr_data;
                default:          cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.failed_threshold <= FAILED_THR_RST;
            cfg_reg.passed_threshold <= PASSED_THR_RST;
            cfg_reg.warning_lamp     <= 1'b0;
            cfg_reg.auto_restore     <= 1'b0;
            cfg_reg.critical_code    <= 1'b0;
            cfg_reg.code_location    <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dtcd_core.sv =====
module dtcd_core
    import dtcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic fault,
    input  cfg_t cfg,
    output res_t result
);

    logic signed [7:0] count_reg, count_next;
    logic failed_reg, failed_next;
    logic confirmed_reg, confirmed_next;
    logic ftc_reg, ftc_next;
    logic nc_reg, nc_next;
    logic lamp_reg, lamp_next;

    logic signed [7:0] ft_s;
    logic [3:0]        lamp_bit;
    verdict_t          verdict;
    logic              store;
    logic [3:0]        store_byte;

    assign ft_s     = {1'b0, cfg.failed_threshold};
    assign lamp_bit = {cfg.warning_lamp, 3'b000};

    always_comb
    begin
        count_next     = count_reg;
        failed_next    = failed_reg;
        confirmed_next = confirmed_reg;
        ftc_next       = ftc_reg;
        nc_next        = nc_reg;
        lamp_next      = lamp_reg;
        verdict        = VERDICT_OPEN;
        store          = 1'b0;
        store_byte     = 4'h0;

        if (fault)
        begin
            if (count_reg < ft_s)
            begin
                // jump to zero when coming from the pass side
                count_next = (count_reg < 8'sd0) ? 8'sd0 : count_reg + 8'sd1;
            end
            else if (!failed_reg)
            begin
                failed_next    = 1'b1;
                confirmed_next = 1'b1;
                ftc_next       = 1'b1;
                nc_next        = 1'b0;
                lamp_next      = cfg.warning_lamp;
                store          = 1'b1;
                store_byte     = BYTE_ON_FAIL | lamp_bit;
                verdict        = VERDICT_FAILED;
            end
        end
        else
        begin
            if (count_reg > cfg.passed_threshold)
            begin
                count_next = (count_reg > 8'sd0) ? 8'sd0 : count_reg - 8'sd1;
            end
            else if (failed_reg || nc_reg)
            begin
                failed_next = 1'b0;
                nc_next     = 1'b0;
                // a failure this cycle holds the code open unless restore is on
                if (!ftc_reg || cfg.auto_restore)
                begin
                    confirmed_next = 1'b1;
                    ftc_next       = 1'b0;
                    lamp_next      = cfg.warning_lamp;
                    store          = 1'b1;
                    store_byte     = BYTE_ON_PASS | lamp_bit;
                    verdict        = VERDICT_PASSED;
                end
            end
            else
            begin
                store      = 1'b1;
                store_byte = BYTE_ON_PASS | {1'b0, ftc_reg, 2'b00} | lamp_bit;
                verdict    = VERDICT_PASSED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 8'sd0;
            failed_reg    <= 1'b0;
            confirmed_reg <= 1'b0;
            ftc_reg       <= 1'b0;
            nc_reg        <= 1'b1;
            lamp_reg      <= 1'b0;
        end
        else if (step)
        begin
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            confirmed_reg <= confirmed_next;
            ftc_reg       <= ftc_next;
            nc_reg        <= nc_next;
            lamp_reg      <= lamp_next;
        end
    end

    assign result.verdict        = verdict;
    assign result.store_request  = store;
    assign result.store_location = cfg.code_location;
    assign result.store_byte     = store_byte;
    assign result.status_flags   = {lamp_next, nc_next, ftc_next, confirmed_next, failed_next};

endmodule

// ===== rtl/dtc_fault_debouncer_top.sv =====
// Each item passes the input register and then the result register. Throughput: one item
// per cycle while the result channel is not stalled; debounce state updates in the same
// cycle as the result.
// A held result does not block the input register from taking one more item.
// Reset (rst_n low, asynchronous): pipeline empty, counter 0, all flags clear except
// not-completed, configuration back to thresholds 10 / -10 and other fields zero.
module dtc_fault_debouncer_top
    import dtcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // test report channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  fault_seen,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            verdict,
    output logic                  store_request,
    output logic [7:0]            store_location,
    output logic [3:0]            store_byte,
    output logic [4:0]            status_flags
);

    cfg_t cfg;
    res_t result;

    logic in_vld_reg;
    logic fault_reg;
    logic out_vld_reg;
    res_t res_reg;

    logic advance;
    logic step;

    // Configuration writes are always taken; the sender must issue them only while no item is in
    // flight, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    dtcd_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register advances when empty or drained this cycle.
    assign advance  = !out_vld_reg || out_ready;
    // An item in the input register is processed when the result slot frees up.
    assign step     = in_vld_reg && advance;
    // The input register refills whenever its item moves on (or it is empty).
    assign in_ready = !in_vld_reg || advance;

    dtcd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .fault  (fault_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register: hold the report until the core consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fault_reg <= fault_seen;
        end
    end

    // Result register: capture the step outcome, hold it while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = out_vld_reg;
    assign verdict        = res_reg.verdict;
    assign store_request  = res_reg.store_request;
    assign store_location = res_reg.store_location;
    assign store_byte     = res_reg.store_byte;
    assign status_flags   = res_reg.status_flags;

    // A store is requested exactly when the test reaches a verdict.
    a_store_iff_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (store_request == (res_reg.verdict != VERDICT_OPEN)))
        else $error("store request does not match verdict");

    // No status byte leaks out without a store request.
    a_byte_zero_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !store_request) |-> (store_byte == 4'h0))
        else $error("status byte set without store request");

    // A failed verdict leaves the fault failed and confirmed, with not-completed clear.
    a_failed_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && res_reg.verdict == VERDICT_FAILED)
            |-> (status_flags[0] && status_flags[1] && !status_flags[3]))
        else $error("failed verdict without failed/confirmed flags");

    // A processed item always shows up in the result register next cycle.
    a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_vld_reg)
        else $error("processed item lost before result register");

endmodule
